>>> hdl/quadrature_encoder_button_events_top_defines.svh
// Assertion macros shared by the encoder and button event checker.
`ifndef QUADRATURE_ENCODER_BUTTON_EVENTS_TOP_DEFINES_SVH
`define QUADRATURE_ENCODER_BUTTON_EVENTS_TOP_DEFINES_SVH

// Property checked on every rising edge while reset is released.
`define QEBE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: property failed");

// Property checked on every rising edge, reset cycles included.
`define QEBE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: property failed");

`endif

>>> hdl/qebe_pkg.sv
// Shared types, constants and the quadrature transition decode for the encoder block.
`default_nettype none

package qebe_pkg;

    // Widths fixed by the item and register formats.
    localparam int CFG_W       = 24;
    localparam int OUT_COUNT_W = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Default parameter values.
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIMER_WIDTH_DEF = 24;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ROT_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_BTN_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS   = 2'd2;
    localparam logic [1:0] REG_DOUBLE_TAP   = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0] ROT_DEBOUNCE_RST = 24'd2000;
    localparam logic [CFG_W-1:0] BTN_DEBOUNCE_RST = 24'd20000;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 24'd1000000;
    localparam logic [CFG_W-1:0] DOUBLE_TAP_RST   = 24'd400000;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } t_rot_ev;

    typedef enum logic [2:0] {
        BTN_NONE    = 3'd0,
        BTN_PRESS   = 3'd1,
        BTN_DOUBLE  = 3'd2,
        BTN_RELEASE = 3'd3,
        BTN_LONG    = 3'd4
    } t_btn_ev;

    typedef struct packed {
        logic [CFG_W-1:0] rotation_debounce;
        logic [CFG_W-1:0] button_debounce;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_tap_window;
    } t_cfg;

    typedef struct packed {
        logic take_press_flag;
        logic clear_position;
        logic take_delta;
        logic pin_switch;
        logic pin_b;
        logic pin_a;
    } t_item;

    typedef struct packed {
        logic                          press_latched;
        logic                          button_held;
        logic signed [OUT_COUNT_W-1:0] step_delta;
        logic signed [OUT_COUNT_W-1:0] position;
        t_btn_ev                       button_event;
        t_rot_ev                       rotation_event;
    } t_result;

    // Direction of one accepted A/B change, from the last decoded state to the new one.
    function automatic t_rot_ev quad_step(input logic [1:0] old_ab, input logic [1:0] new_ab);
        t_rot_ev dir;
        case ({old_ab, new_ab})
            4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: dir = ROT_CW;
            4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: dir = ROT_CCW;
            default:                                dir = ROT_NONE;
        endcase
        return dir;
    endfunction

endpackage

`default_nettype wire

>>> hdl/qebe_core.sv
// Per-sample state update: debounce timers, quadrature decode, counters and button events.
`default_nettype none

module qebe_core #(
    parameter int COUNT_WIDTH = qebe_pkg::COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = qebe_pkg::TIMER_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  qebe_pkg::t_item  i_item,
    input  qebe_pkg::t_cfg   i_cfg,
    output qebe_pkg::t_result o_result
);
    import qebe_pkg::*;

    localparam int CMP_W = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;
    localparam int EXT_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;
    localparam logic [TIMER_WIDTH-1:0] TIMER_TOP = '1;

    // Saturating tick of one timer.
    function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] t);
        return (t == TIMER_TOP) ? t : t + TIMER_WIDTH'(1);
    endfunction

    logic                   r_primed, n_primed;
    logic [1:0]             r_prev_ab, n_prev_ab;
    logic [1:0]             r_dec_ab, n_dec_ab;
    logic                   r_prev_sw, n_prev_sw;
    logic [COUNT_WIDTH-1:0] r_pos, n_pos;
    logic [COUNT_WIDTH-1:0] r_acc, n_acc;
    logic [TIMER_WIDTH-1:0] r_rot_el, n_rot_el;
    logic [TIMER_WIDTH-1:0] r_sw_el, n_sw_el;
    logic [TIMER_WIDTH-1:0] r_tap_el, n_tap_el;
    logic [TIMER_WIDTH-1:0] r_hold_el, n_hold_el;
    logic                   r_held, n_held;
    logic                   r_press, n_press;
    logic                   r_long, n_long;
    logic                   r_await, n_await;

    // Next state and the result for the item in the input register.
    always_comb begin
        logic [1:0]             ab;
        logic [COUNT_WIDTH-1:0] pos_upd;
        logic [COUNT_WIDTH-1:0] acc_upd;
        logic signed [EXT_W-1:0] pos_ext;
        logic signed [EXT_W-1:0] acc_ext;
        t_rot_ev                rot_ev;
        t_btn_ev                btn_ev;

        ab        = {i_item.pin_a, i_item.pin_b};
        rot_ev    = ROT_NONE;
        btn_ev    = BTN_NONE;
        n_primed  = r_primed;
        n_prev_ab = r_prev_ab;
        n_dec_ab  = r_dec_ab;
        n_prev_sw = r_prev_sw;
        pos_upd   = r_pos;
        acc_upd   = r_acc;
        n_rot_el  = sat_inc(r_rot_el);
        n_sw_el   = sat_inc(r_sw_el);
        n_tap_el  = sat_inc(r_tap_el);
        n_hold_el = r_held ? sat_inc(r_hold_el) : r_hold_el;
        n_held    = r_held;
        n_press   = r_press;
        n_long    = r_long;
        n_await   = r_await;

        if (!r_primed) begin
            // First sample only captures the pin levels.
            n_primed  = 1'b1;
            n_prev_ab = ab;
            n_dec_ab  = ab;
            n_prev_sw = i_item.pin_switch;
        end else begin
            // Encoder pins: a change is decoded only once the debounce time has passed.
            if (ab != r_prev_ab) begin
                n_prev_ab = ab;
                if (CMP_W'(n_rot_el) >= CMP_W'(i_cfg.rotation_debounce)) begin
                    rot_ev   = quad_step(r_dec_ab, ab);
                    n_rot_el = '0;
                    n_dec_ab = ab;
                    case (rot_ev)
                        ROT_CW: begin
                            pos_upd = r_pos + COUNT_WIDTH'(1);
                            acc_upd = r_acc + COUNT_WIDTH'(1);
                        end
                        ROT_CCW: begin
                            pos_upd = r_pos - COUNT_WIDTH'(1);
                            acc_upd = r_acc - COUNT_WIDTH'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // Switch pin: same debounce rule, then press, double tap or release.
            if (i_item.pin_switch != r_prev_sw) begin
                n_prev_sw = i_item.pin_switch;
                if (CMP_W'(n_sw_el) >= CMP_W'(i_cfg.button_debounce)) begin
                    n_sw_el = '0;
                    if (!i_item.pin_switch && !r_held) begin
                        n_held    = 1'b1;
                        n_press   = 1'b1;
                        n_hold_el = '0;
                        n_long    = 1'b0;
                        if (r_await &&
                            (CMP_W'(n_tap_el) < CMP_W'(i_cfg.double_tap_window))) begin
                            n_await = 1'b0;
                            btn_ev  = BTN_DOUBLE;
                        end else begin
                            n_await  = 1'b1;
                            n_tap_el = '0;
                            btn_ev   = BTN_PRESS;
                        end
                    end else if (i_item.pin_switch && r_held) begin
                        n_held = 1'b0;
                        btn_ev = BTN_RELEASE;
                    end
                end
            end
        end

        // Long press fires once per press, on a sample without another button event.
        if ((btn_ev == BTN_NONE) && n_held && !n_long &&
            (CMP_W'(n_hold_el) >= CMP_W'(i_cfg.long_press_ticks))) begin
            n_long = 1'b1;
            btn_ev = BTN_LONG;
        end

        // Report counters sign-extended from their own width.
        pos_ext = EXT_W'($signed(pos_upd));
        acc_ext = EXT_W'($signed(acc_upd));

        o_result.rotation_event = rot_ev;
        o_result.button_event   = btn_ev;
        o_result.position       = pos_ext[OUT_COUNT_W-1:0];
        o_result.step_delta     = acc_ext[OUT_COUNT_W-1:0];
        o_result.button_held    = n_held;
        o_result.press_latched  = n_press;

        // Read-and-clear requests act after the report.
        n_pos = pos_upd;
        n_acc = acc_upd;
        if (i_item.take_delta) begin
            n_acc = '0;
        end
        if (i_item.clear_position) begin
            n_pos = '0;
            n_acc = '0;
        end
        if (i_item.take_press_flag) begin
            n_press = 1'b0;
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed  <= 1'b0;
            r_pos     <= '0;
            r_acc     <= '0;
            r_rot_el  <= TIMER_TOP;
            r_sw_el   <= TIMER_TOP;
            r_tap_el  <= TIMER_TOP;
            r_hold_el <= '0;
            r_held    <= 1'b0;
            r_press   <= 1'b0;
            r_long    <= 1'b0;
            r_await   <= 1'b0;
        end else if (i_step) begin
            r_primed  <= n_primed;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_rot_el  <= n_rot_el;
            r_sw_el   <= n_sw_el;
            r_tap_el  <= n_tap_el;
            r_hold_el <= n_hold_el;
            r_held    <= n_held;
            r_press   <= n_press;
            r_long    <= n_long;
            r_await   <= n_await;
        end
    end

    // Captured pin samples; meaningful only once primed.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_prev_ab <= n_prev_ab;
            r_dec_ab  <= n_dec_ab;
            r_prev_sw <= n_prev_sw;
        end
    end

endmodule

`default_nettype wire

>>> hdl/quadrature_encoder_button_events_top.sv
// Each sample passes the input register, then its result is offered from the result register.
// Throughput: one sample per cycle; the state update for a sample is a single
// register-to-register pass, and the sample side stalls only while both registers are full.
// Reset (synchronous, active low) empties both registers, restores the register defaults,
// zeroes position and delta, saturates the debounce and tap timers and waits for a first sample.
`default_nettype none

module quadrature_encoder_button_events_top #(
    parameter int COUNT_WIDTH = qebe_pkg::COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = qebe_pkg::TIMER_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample stream.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata from bit 0: pin_a, pin_b, pin_switch, take_delta, clear_position,
    // take_press_flag, two zero bits.
    input  logic [qebe_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // Result stream.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata from bit 0: rotation_event[1:0], button_event[4:2], position[36:5],
    // step_delta[68:37], button_held[69], press_latched[70], one zero bit.
    output logic [qebe_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [qebe_pkg::CFG_W-1:0]       i_cfg_data
);
    import qebe_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_cfg    r_cfg;
    t_result core_result;
    logic    advance;
    logic    in_xfer;

    // A sample advances when the result register is free or being drained.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation_debounce <= ROT_DEBOUNCE_RST;
            r_cfg.button_debounce   <= BTN_DEBOUNCE_RST;
            r_cfg.long_press_ticks  <= LONG_PRESS_RST;
            r_cfg.double_tap_window <= DOUBLE_TAP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROT_DEBOUNCE: r_cfg.rotation_debounce <= i_cfg_data;
                REG_BTN_DEBOUNCE: r_cfg.button_debounce   <= i_cfg_data;
                REG_LONG_PRESS:   r_cfg.long_press_ticks  <= i_cfg_data;
                REG_DOUBLE_TAP:   r_cfg.double_tap_window <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= t_item'(i_s_axis_tdata[$bits(t_item)-1:0]);
        end
    end

    qebe_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0,
                              r_out.press_latched,
                              r_out.button_held,
                              r_out.step_delta,
                              r_out.position,
                              r_out.button_event,
                              r_out.rotation_event};

endmodule

`default_nettype wire

>>> hdl/qebe_checker.sv
// Port-level checks for the encoder and button event block, bound to the top level.
`default_nettype none

`include "quadrature_encoder_button_events_top_defines.svh"

module qebe_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_s_axis_tready,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [qebe_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import qebe_pkg::*;

    // A stalled result stays offered and unchanged.
    `QEBE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))

    // The sample side only stalls while a result is waiting.
    `QEBE_ASSERT(a_stall_needs_result, i_clk, i_rst_n, !o_s_axis_tready |-> o_m_axis_tvalid)

    // A press or double tap reports the button held and the press flag set.
    `QEBE_ASSERT(a_press_flags, i_clk, i_rst_n, (o_m_axis_tvalid && ((o_m_axis_tdata[4:2] == BTN_PRESS) || (o_m_axis_tdata[4:2] == BTN_DOUBLE))) |-> (o_m_axis_tdata[69] && o_m_axis_tdata[70]))

    // A release reports the button up; a long press reports it down.
    `QEBE_ASSERT(a_release_long, i_clk, i_rst_n, (o_m_axis_tvalid && ((o_m_axis_tdata[4:2] == BTN_RELEASE) || (o_m_axis_tdata[4:2] == BTN_LONG))) |-> (o_m_axis_tdata[69] == (o_m_axis_tdata[4:2] == BTN_LONG)))

    // Reset leaves no result offered.
    `QEBE_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)

endmodule

bind quadrature_encoder_button_events_top qebe_checker u_qebe_checker (.*);

`default_nettype wire

>>> tb/qebe_event_check.sv
// Stream monitor that predicts every encoder and button result and compares it on arrival.
`timescale 1ns / 100ps

module qebe_event_check (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    // tdata from bit 0: pin_a, pin_b, pin_switch, take_delta, clear_position,
    // take_press_flag, two zero bits.
    input  logic [qebe_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    // tdata from bit 0: rotation_event, button_event, position, step_delta,
    // button_held, press_latched, one zero bit.
    input  logic [qebe_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                             i_cfg_we,
    input  logic [1:0]                       i_cfg_index,
    input  logic [qebe_pkg::CFG_W-1:0]       i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import qebe_pkg::*;

    localparam int TIMER_W = TIMER_WIDTH_DEF;

    // Direction of an accepted A/B change, indexed by {decoded state, new pins}.
    localparam t_rot_ev STEP_DIR [16] = '{
        ROT_NONE, ROT_CW,   ROT_CCW,  ROT_NONE,
        ROT_CCW,  ROT_NONE, ROT_NONE, ROT_CW,
        ROT_CW,   ROT_NONE, ROT_NONE, ROT_CCW,
        ROT_NONE, ROT_CCW,  ROT_CW,   ROT_NONE
    };

    // Shadow copy of the block's registers and state.
    t_cfg                   settings;
    logic                   primed;
    logic [1:0]             last_ab;
    logic [1:0]             decoded_ab;
    logic                   last_switch;
    logic [OUT_COUNT_W-1:0] position_q;
    logic [OUT_COUNT_W-1:0] delta_q;
    logic [TIMER_W-1:0]     rot_timer;
    logic [TIMER_W-1:0]     switch_timer;
    logic [TIMER_W-1:0]     hold_timer;
    logic [TIMER_W-1:0]     tap_timer;
    logic                   held_q;
    logic                   press_q;
    logic                   long_done;
    logic                   second_tap_armed;

    t_result                expected_results[$];
    int                     fail_count = 0;

    // Timers count up once per sample and stick at all ones.
    function automatic logic [TIMER_W-1:0] timer_tick(input logic [TIMER_W-1:0] t);
        return (t == '1) ? t : t + 1'b1;
    endfunction

    // Work out the result of one accepted sample and queue it.
    task automatic predict_sample(input t_item it);
        logic [1:0] ab;
        t_rot_ev    dir;
        t_result    r;
        ab = {it.pin_a, it.pin_b};
        r.rotation_event = ROT_NONE;
        r.button_event   = BTN_NONE;

        rot_timer    = timer_tick(rot_timer);
        switch_timer = timer_tick(switch_timer);
        tap_timer    = timer_tick(tap_timer);
        if (held_q)
            hold_timer = timer_tick(hold_timer);

        if (!primed) begin
            // The first sample only captures the pin levels.
            primed      = 1'b1;
            last_ab     = ab;
            decoded_ab  = ab;
            last_switch = it.pin_switch;
        end else begin
            // Encoder pins: a change is remembered even when debounce rejects it.
            if (ab != last_ab) begin
                last_ab = ab;
                if (rot_timer >= settings.rotation_debounce) begin
                    dir       = STEP_DIR[{decoded_ab, ab}];
                    rot_timer = '0;
                    if (dir == ROT_CW) begin
                        position_q = position_q + 1'b1;
                        delta_q    = delta_q + 1'b1;
                    end else if (dir == ROT_CCW) begin
                        position_q = position_q - 1'b1;
                        delta_q    = delta_q - 1'b1;
                    end
                    r.rotation_event = dir;
                    decoded_ab       = ab;
                end
            end
            // Switch pin: a taken change that agrees with the held state is silent.
            if (it.pin_switch != last_switch) begin
                last_switch = it.pin_switch;
                if (switch_timer >= settings.button_debounce) begin
                    switch_timer = '0;
                    if (!it.pin_switch && !held_q) begin
                        held_q     = 1'b1;
                        press_q    = 1'b1;
                        hold_timer = '0;
                        long_done  = 1'b0;
                        if (second_tap_armed && tap_timer < settings.double_tap_window) begin
                            second_tap_armed = 1'b0;
                            r.button_event   = BTN_DOUBLE;
                        end else begin
                            second_tap_armed = 1'b1;
                            tap_timer        = '0;
                            r.button_event   = BTN_PRESS;
                        end
                    end else if (it.pin_switch && held_q) begin
                        held_q         = 1'b0;
                        r.button_event = BTN_RELEASE;
                    end
                end
            end
        end

        // The long press only fires on a sample without an edge event.
        if (r.button_event == BTN_NONE && held_q && !long_done &&
            hold_timer >= settings.long_press_ticks) begin
            long_done      = 1'b1;
            r.button_event = BTN_LONG;
        end

        r.position      = position_q;
        r.step_delta    = delta_q;
        r.button_held   = held_q;
        r.press_latched = press_q;
        expected_results.push_back(r);

        // Read-and-clear requests act after the report.
        if (it.take_delta)
            delta_q = '0;
        if (it.clear_position) begin
            position_q = '0;
            delta_q    = '0;
        end
        if (it.take_press_flag)
            press_q = 1'b0;
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Follow resets, register writes and both stream channels.
    always @(posedge i_clk) begin : watch_streams
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            settings.rotation_debounce = ROT_DEBOUNCE_RST;
            settings.button_debounce   = BTN_DEBOUNCE_RST;
            settings.long_press_ticks  = LONG_PRESS_RST;
            settings.double_tap_window = DOUBLE_TAP_RST;
            primed           = 1'b0;
            last_ab          = '0;
            decoded_ab       = '0;
            last_switch      = 1'b0;
            position_q       = '0;
            delta_q          = '0;
            rot_timer        = '1;
            switch_timer     = '1;
            tap_timer        = '1;
            hold_timer       = '0;
            held_q           = 1'b0;
            press_q          = 1'b0;
            long_done        = 1'b0;
            second_tap_armed = 1'b0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROT_DEBOUNCE: settings.rotation_debounce = i_cfg_data;
                    REG_BTN_DEBOUNCE: settings.button_debounce   = i_cfg_data;
                    REG_LONG_PRESS:   settings.long_press_ticks  = i_cfg_data;
                    REG_DOUBLE_TAP:   settings.double_tap_window = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                predict_sample(t_item'(i_s_tdata[$bits(t_item)-1:0]));
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer arrived with no sample waiting for it");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    got  = t_result'(i_m_tdata[$bits(t_result)-1:0]);
                    check_field("rotation_event", longint'(want.rotation_event),
                                longint'(got.rotation_event));
                    check_field("button_event", longint'(want.button_event),
                                longint'(got.button_event));
                    check_field("position", longint'(want.position), longint'(got.position));
                    check_field("step_delta", longint'(want.step_delta),
                                longint'(got.step_delta));
                    check_field("button_held", longint'(want.button_held),
                                longint'(got.button_held));
                    check_field("press_latched", longint'(want.press_latched),
                                longint'(got.press_latched));
                    check_field("pad", 0, longint'(i_m_tdata[OUT_TDATA_W-1]));
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = fail_count;
    end

endmodule

>>> tb/testbench.sv
// Top of the encoder and button event test: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module testbench;
    import qebe_pkg::*;

    localparam int LATENCY     = 2;
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 4000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [CFG_W-1:0]       cfg_data;
    int                     fail_count;
    int                     pending;

    // Pacing controls: idle_on and quiet for sender and receiver, hold_req for receiver.
    logic                   idle_on   = 1'b1;
    logic                   quiet     = 1'b0;
    logic                   hold_req  = 1'b0;

    // Random walk state for the encoder and the switch.
    logic [1:0]             enc_ab    = 2'b00;
    logic                   spin_cw   = 1'b1;
    logic                   sw_level  = 1'b1;
    int                     rot_wait  = 0;
    int                     sw_wait   = 0;
    int                     stall_cycles = 0;

    quadrature_encoder_button_events_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    qebe_event_check u_event_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: too many cycles without any transfer or register write ends the run.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one sample and wait for its transfer; may idle first.
    task automatic send_sample(input logic a, b, sw, td, cp, tp);
        t_item it;
        it = '{take_press_flag: tp, clear_position: cp, take_delta: td,
               pin_switch: sw, pin_b: b, pin_a: a};
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - $bits(t_item)){1'b0}}, it};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Drain the block, then write all four registers.
    task automatic write_settings(input logic [CFG_W-1:0] rot, btn, lng, tap);
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (LATENCY + 2) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_ROT_DEBOUNCE;
        cfg_data  <= rot;
        @(negedge i_clk);
        cfg_index <= REG_BTN_DEBOUNCE;
        cfg_data  <= btn;
        @(negedge i_clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data  <= lng;
        @(negedge i_clk);
        cfg_index <= REG_DOUBLE_TAP;
        cfg_data  <= tap;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly clean Gray-code rotation and switch presses, with bounces and noise.
    task automatic run_phase(input int count, input int rot_span, input int sw_span);
        int k;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (rot_wait == 0) begin
                k = $urandom_range(0, 15);
                if (k >= 11 && k < 13)
                    spin_cw = ~spin_cw;
                if (k < 13)
                    enc_ab = spin_cw ? {enc_ab[0], ~enc_ab[1]} : {~enc_ab[0], enc_ab[1]};
                else if (k == 13)
                    enc_ab = ~enc_ab;
                else
                    enc_ab = 2'($urandom_range(0, 3));
                rot_wait = $urandom_range(0, rot_span);
            end else begin
                rot_wait--;
            end
            if (sw_wait == 0) begin
                sw_level = ~sw_level;
                sw_wait  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2)
                                                       : $urandom_range(1, sw_span);
            end else begin
                sw_wait--;
            end
            send_sample(enc_ab[1], enc_ab[0], sw_level,
                        ($urandom_range(0, 7) == 0), ($urandom_range(0, 31) == 0),
                        ($urandom_range(0, 5) == 0));
        end
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROT_DEBOUNCE;
        cfg_data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset defaults: first sample takes pins; debounce passes one change per input.
        send_sample(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        // No debounce, immediate long press, any second press is a double tap.
        write_settings('0, '0, '0, '1);
        send_sample(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
        send_sample(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        send_sample(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_sample(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
        send_sample(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);

        // Random phases over several register settings, both extremes included.
        write_settings('0, '0, '0, '0);
        run_phase(180, 2, 6);

        write_settings(24'd1, 24'd2, 24'd8, 24'd20);
        run_phase(90, 4, 24);
        hold_req = 1'b1;
        run_phase(90, 4, 24);

        write_settings(24'd3, 24'd4, 24'd25, 24'd60);
        run_phase(180, 8, 60);

        write_settings('1, '1, '1, '1);
        run_phase(60, 3, 10);

        write_settings('0, 24'd1, 24'd3, '1);
        run_phase(160, 2, 12);

        write_settings(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 6)),
                       CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 80)));
        run_phase(170, 10, 50);

        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        write_settings(CFG_W'($urandom_range(0, 4)), CFG_W'($urandom_range(0, 6)),
                       CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 80)));
        run_phase(140, 6, 30);

        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (LATENCY + 6) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
